>>> hdl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, codes and parameter defaults of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned MAX_ITEMS_DEF  = 1024;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// request kind carried by req_type
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_LOADED = 2'd0,
		ST_READ   = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// merge sequencer states
	typedef enum logic [3:0] {
		M_IDLE,
		M_SEG,
		M_RDA,
		M_CAPA,
		M_CAPB,
		M_STEP,
		M_REFA,
		M_REFB,
		M_DONE
	} merge_state_t;

	// top level request states
	typedef enum logic [2:0] {
		T_IDLE,
		T_SORT,
		T_CHK,
		T_RD,
		T_RESP
	} top_state_t;

	// control and status from the merge sequencer to the top level
	typedef struct packed {
		logic rd_bank;   // bank being read (source of the pass)
		logic wr_en;     // merge write this cycle
		logic wr_bank;   // bank being written (destination of the pass)
		logic done;      // sort finished, one cycle
		logic res_bank;  // bank holding the sorted set when done
	} merge_ctl_t;

endpackage

>>> hdl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Single bank of element storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int unsigned DEPTH = mse_pkg::MAX_ITEMS_DEF,
	parameter int unsigned DW    = mse_pkg::DATA_WIDTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hdl/mse_merge.sv
// ----------------------------------------------------------------------------
// mse_merge
// Bottom-up merge sequencer. Each pass merges run pairs from the source bank
// into the destination bank with one shared signed comparator, then the
// banks swap roles. Run width doubles every pass.
// ----------------------------------------------------------------------------
module mse_merge #(
	parameter int unsigned MAX_ITEMS  = mse_pkg::MAX_ITEMS_DEF,
	parameter int unsigned DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]       n,
	output logic [$clog2(MAX_ITEMS)-1:0]         rd_addr,
	input  logic [DATA_WIDTH-1:0]                rd_data,
	output logic [$clog2(MAX_ITEMS)-1:0]         wr_addr,
	output logic [DATA_WIDTH-1:0]                wr_data,
	output mse_pkg::merge_ctl_t                  ctl
);

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned PW = CW + 2;

	mse_pkg::merge_state_t state_q, state_d;

	logic                         src_q;
	logic [PW-1:0]                n_q, width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic signed [DATA_WIDTH-1:0] head_a_q, head_b_q;

	logic [PW-1:0] lo_w, mid_c, mid_w, hi_c, a_nx, b_nx, width2;
	logic          a_ok, b_ok, take_a, pass_end;

	// run bounds of the next segment
	assign lo_w   = lo_q + width_q;
	assign mid_c  = (lo_w < n_q) ? lo_w : n_q;
	assign mid_w  = mid_c + width_q;
	assign hi_c   = (mid_w < n_q) ? mid_w : n_q;
	assign width2 = width_q << 1;
	assign pass_end = (lo_q >= n_q);

	// shared comparator: take from run A on ties to keep load order
	assign a_ok   = (a_q < mid_q);
	assign b_ok   = (b_q < hi_q);
	assign take_a = a_ok && (!b_ok || (head_a_q <= head_b_q));
	assign a_nx   = a_q + PW'(1);
	assign b_nx   = b_q + PW'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::M_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory strobes
	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.rd_bank  = src_q;
		ctl.wr_bank  = ~src_q;
		ctl.res_bank = src_q;
		rd_addr      = a_q[AW-1:0];
		wr_addr      = k_q[AW-1:0];
		wr_data      = take_a ? head_a_q : head_b_q;
		case (state_q)
			mse_pkg::M_IDLE: begin
				if (start) begin
					state_d = (n < CW'(2)) ? mse_pkg::M_DONE : mse_pkg::M_SEG;
				end
			end
			mse_pkg::M_SEG: begin
				if (pass_end) begin
					state_d = (width2 >= n_q) ? mse_pkg::M_DONE : mse_pkg::M_SEG;
				end else begin
					state_d = mse_pkg::M_RDA;
				end
			end
			mse_pkg::M_RDA: begin
				rd_addr = a_q[AW-1:0];
				state_d = mse_pkg::M_CAPA;
			end
			mse_pkg::M_CAPA: begin
				rd_addr = b_q[AW-1:0];
				state_d = mse_pkg::M_CAPB;
			end
			mse_pkg::M_CAPB: begin
				state_d = mse_pkg::M_STEP;
			end
			mse_pkg::M_STEP: begin
				if (k_q == hi_q) begin
					state_d = mse_pkg::M_SEG;
				end else begin
					ctl.wr_en = 1'b1;
					if (take_a) begin
						rd_addr = a_nx[AW-1:0];
						state_d = mse_pkg::M_REFA;
					end else begin
						rd_addr = b_nx[AW-1:0];
						state_d = mse_pkg::M_REFB;
					end
				end
			end
			mse_pkg::M_REFA: begin
				state_d = mse_pkg::M_STEP;
			end
			mse_pkg::M_REFB: begin
				state_d = mse_pkg::M_STEP;
			end
			mse_pkg::M_DONE: begin
				ctl.done = 1'b1;
				state_d  = mse_pkg::M_IDLE;
			end
			default: begin
				state_d = mse_pkg::M_IDLE;
			end
		endcase
	end

	// source bank: clear on start, swap at the end of each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 1'b0;
		end else if (state_q == mse_pkg::M_IDLE && start) begin
			src_q <= 1'b0;
		end else if (state_q == mse_pkg::M_SEG && pass_end) begin
			src_q <= ~src_q;
		end
	end

	// run pointers and head values
	always_ff @(posedge clk) begin
		case (state_q)
			mse_pkg::M_IDLE: begin
				if (start) begin
					n_q     <= PW'(n);
					width_q <= PW'(1);
					lo_q    <= '0;
				end
			end
			mse_pkg::M_SEG: begin
				if (pass_end) begin
					width_q <= width2;
					lo_q    <= '0;
				end else begin
					mid_q <= mid_c;
					hi_q  <= hi_c;
					a_q   <= lo_q;
					b_q   <= mid_c;
					k_q   <= lo_q;
				end
			end
			mse_pkg::M_CAPA: begin
				head_a_q <= rd_data;
			end
			mse_pkg::M_CAPB: begin
				head_b_q <= rd_data;
			end
			mse_pkg::M_STEP: begin
				if (k_q == hi_q) begin
					lo_q <= lo_q + width2;
				end else begin
					k_q <= k_q + PW'(1);
					if (take_a) begin
						a_q <= a_nx;
					end else begin
						b_q <= b_nx;
					end
				end
			end
			mse_pkg::M_REFA: begin
				head_a_q <= rd_data;
			end
			mse_pkg::M_REFB: begin
				head_b_q <= rd_data;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/merge_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// Loads signed values into a set, sorts the set ascending by merge sort on
// the first read, and returns one value per read.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+--------------------------------------
//   request | in_valid  | in_ready  | req_type, load_value
//   result  | out_valid | out_ready | sorted_value, is_last, status
//
// The first read after loading n values runs the sort first: ceil(log2 n)
// passes, each with one bank read per element through the single read port.
// No clearing pass after reset; the storage needs no initialization.
// in_ready is high only while no item is in work; a result waits in the
// output register while the next item is taken.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit #(
	parameter int unsigned MAX_ITEMS  = mse_pkg::MAX_ITEMS_DEF,
	parameter int unsigned DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic signed [DATA_WIDTH-1:0] load_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] sorted_value,
	output logic                         is_last,
	output logic [1:0]                   status
);

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	mse_pkg::top_state_t state_q, state_d;

	logic [CW-1:0]   count_q, pos_q, eff_count;
	logic            reading_q, bank_q;
	logic            out_valid_q;
	mse_pkg::status_t res_status_q, status_q;
	logic [DATA_WIDTH-1:0] res_value_q, sorted_value_q;
	logic            res_last_q, is_last_q;

	logic            accept, is_load, load_ok, load_we, merge_start, sorting, slot_free;
	logic            pos_end;

	mse_pkg::merge_ctl_t   mctl;
	logic [AW-1:0]         m_rd_addr, m_wr_addr, rd_addr, wr_addr;
	logic [DATA_WIDTH-1:0] m_wr_data, wr_data, rd0, rd1, rd_sel;
	logic                  we0, we1;

	// request decode
	assign in_ready  = (state_q == mse_pkg::T_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_load   = (mse_pkg::req_t'(req_type) == mse_pkg::REQ_LOAD);
	assign eff_count = reading_q ? '0 : count_q;
	assign load_ok   = (eff_count < CW'(MAX_ITEMS));
	assign load_we   = accept && is_load && load_ok;
	assign sorting   = (state_q == mse_pkg::T_SORT);
	assign slot_free = !out_valid_q || out_ready;
	assign pos_end   = (pos_q >= count_q);

	// bank port steering
	assign rd_addr = sorting ? m_rd_addr : pos_q[AW-1:0];
	assign rd_sel  = (sorting ? mctl.rd_bank : bank_q) ? rd1 : rd0;
	assign wr_addr = mctl.wr_en ? m_wr_addr : eff_count[AW-1:0];
	assign wr_data = mctl.wr_en ? m_wr_data : load_value;
	assign we0     = load_we || (mctl.wr_en && !mctl.wr_bank);
	assign we1     = mctl.wr_en && mctl.wr_bank;

	mse_ram #(
		.DEPTH (MAX_ITEMS),
		.DW    (DATA_WIDTH),
		.AW    (AW)
	) u_bank0 (
		.clk     (clk),
		.wr_en   (we0),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd0)
	);

	mse_ram #(
		.DEPTH (MAX_ITEMS),
		.DW    (DATA_WIDTH),
		.AW    (AW)
	) u_bank1 (
		.clk     (clk),
		.wr_en   (we1),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd1)
	);

	mse_merge #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (merge_start),
		.n       (count_q),
		.rd_addr (m_rd_addr),
		.rd_data (rd_sel),
		.wr_addr (m_wr_addr),
		.wr_data (m_wr_data),
		.ctl     (mctl)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d     = state_q;
		merge_start = 1'b0;
		case (state_q)
			mse_pkg::T_IDLE: begin
				if (accept) begin
					if (is_load) begin
						state_d = mse_pkg::T_RESP;
					end else if (!reading_q) begin
						merge_start = 1'b1;
						state_d     = mse_pkg::T_SORT;
					end else begin
						state_d = mse_pkg::T_CHK;
					end
				end
			end
			mse_pkg::T_SORT: begin
				if (mctl.done) begin
					state_d = mse_pkg::T_CHK;
				end
			end
			mse_pkg::T_CHK: begin
				state_d = pos_end ? mse_pkg::T_RESP : mse_pkg::T_RD;
			end
			mse_pkg::T_RD: begin
				state_d = mse_pkg::T_RESP;
			end
			mse_pkg::T_RESP: begin
				if (slot_free) begin
					state_d = mse_pkg::T_IDLE;
				end
			end
			default: begin
				state_d = mse_pkg::T_IDLE;
			end
		endcase
	end

	// set bookkeeping and result handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			reading_q   <= 1'b0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on handoff, drop it once the beat is taken
			if (state_q == mse_pkg::T_RESP && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mse_pkg::T_IDLE: begin
					if (accept) begin
						if (is_load) begin
							// a load after reads starts a new set
							count_q   <= load_ok ? eff_count + CW'(1) : eff_count;
							pos_q     <= reading_q ? '0 : pos_q;
							bank_q    <= reading_q ? 1'b0 : bank_q;
							reading_q <= 1'b0;
						end else if (!reading_q) begin
							reading_q <= 1'b1;
							pos_q     <= '0;
						end
					end
				end
				mse_pkg::T_SORT: begin
					if (mctl.done) begin
						bank_q <= mctl.res_bank;
					end
				end
				mse_pkg::T_RD: begin
					pos_q <= pos_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// result and output registers
	always_ff @(posedge clk) begin
		case (state_q)
			mse_pkg::T_IDLE: begin
				if (accept && is_load) begin
					res_value_q  <= '0;
					res_last_q   <= 1'b0;
					res_status_q <= load_ok ? mse_pkg::ST_LOADED : mse_pkg::ST_FULL;
				end
			end
			mse_pkg::T_CHK: begin
				res_value_q  <= '0;
				res_last_q   <= 1'b0;
				res_status_q <= mse_pkg::ST_EMPTY;
			end
			mse_pkg::T_RD: begin
				res_value_q  <= rd_sel;
				res_last_q   <= ((pos_q + CW'(1)) == count_q);
				res_status_q <= mse_pkg::ST_READ;
			end
			mse_pkg::T_RESP: begin
				if (slot_free) begin
					sorted_value_q <= res_value_q;
					is_last_q      <= res_last_q;
					status_q       <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign is_last      = is_last_q;
	assign status       = status_q;

	// count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("loaded count exceeds store depth");

	// read position never passes the loaded count in the read phase
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reading_q |-> (pos_q <= count_q))
		else $error("read position beyond loaded count");

	// merge writes only while the sort runs
	a_merge_wr: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.wr_en |-> (state_q == mse_pkg::T_SORT))
		else $error("merge write outside sort");

	// a sort start is followed by the top level entering the sort state
	a_merge_go: assert property (@(posedge clk) disable iff (!arst_n)
		merge_start |=> (state_q == mse_pkg::T_SORT))
		else $error("sort start did not enter sort state");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for merge_sort_engine_unit. A model of the sorted set
// tracks every accepted request beat and predicts its result. Each result
// beat is compared field by field with the oldest prediction. Stimulus runs
// directed corner cases first, then a receiver hold-off, then a set that
// overfills the store, then random sets with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned DW          = mse_pkg::DATA_WIDTH_DEF;
	localparam int          MAX_N       = mse_pkg::MAX_ITEMS_DEF;
	localparam int          RAND_ITEMS  = 450;
	localparam int          CYCLE_LIMIT = 2000000;
	localparam int          HOLD_CYCLES = 400;

	localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

	typedef struct {
		logic signed [DW-1:0] value;
		logic                 last;
		mse_pkg::status_t     st;
	} sort_result_t;

	// Model of the loaded set: predicts one result per request beat
	class sorted_set_model;
		logic signed [DW-1:0] set_vals[MAX_N];
		int                   set_count;
		int                   read_pos;
		bit                   reading;
		sort_result_t         due_results[$];
		int                   errors;

		function new();
			set_count = 0;
			read_pos  = 0;
			reading   = 1'b0;
			errors    = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Put the loaded values in ascending order
		function void order_set();
			logic signed [DW-1:0] key;
			int                   j;
			for (int i = 1; i < set_count; i++) begin
				key = set_vals[i];
				j = i - 1;
				while (j >= 0 && set_vals[j] > key) begin
					set_vals[j+1] = set_vals[j];
					j--;
				end
				set_vals[j+1] = key;
			end
		endfunction

		function void note_request(logic kind, logic signed [DW-1:0] val);
			sort_result_t r;
			r.value = '0;
			r.last  = 1'b0;
			if (kind == mse_pkg::REQ_LOAD) begin
				// a load after reads starts a new set
				if (reading) begin
					set_count = 0;
					read_pos  = 0;
					reading   = 1'b0;
				end
				if (set_count >= MAX_N) begin
					r.st = mse_pkg::ST_FULL;
				end else begin
					set_vals[set_count] = val;
					set_count++;
					r.st = mse_pkg::ST_LOADED;
				end
			end else begin
				// first read of a set sorts it
				if (!reading) begin
					order_set();
					reading  = 1'b1;
					read_pos = 0;
				end
				if (read_pos >= set_count) begin
					r.st = mse_pkg::ST_EMPTY;
				end else begin
					r.value = set_vals[read_pos];
					r.last  = (read_pos + 1 == set_count);
					read_pos++;
					r.st = mse_pkg::ST_READ;
				end
			end
			due_results.push_back(r);
		endfunction

		function void flag(string field, logic signed [63:0] expv, logic signed [63:0] actv);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, field, expv, actv);
		endfunction

		function void check_result(logic signed [DW-1:0] value, logic last, logic [1:0] st);
			sort_result_t exp_r;
			if (due_results.size() == 0) begin
				errors++;
				$display({"%0t: result beat with nothing outstanding, expected none,",
					" actual value %0d last %0d status %0d"},
					$time, value, last, st);
				return;
			end
			exp_r = due_results.pop_front();
			if (value !== exp_r.value)
				flag("sorted_value", exp_r.value, value);
			if (last !== exp_r.last)
				flag("is_last", exp_r.last, last);
			if (st !== exp_r.st)
				flag("status", exp_r.st, st);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic signed [DW-1:0] load_value;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [DW-1:0] sorted_value;
	logic                 is_last;
	logic [1:0]           status;

	sorted_set_model sb;
	bit              idle_on;
	bit              long_hold_req;
	int              sent_count;
	int              cycle_count;

	merge_sort_engine_unit #(
		.MAX_ITEMS (MAX_N),
		.DATA_WIDTH(DW)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.load_value  (load_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sorted_value(sorted_value),
		.is_last     (is_last),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Record accepted request beats
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(req_type, load_value);
	end

	// Check accepted result beats
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(sorted_value, is_last, status);
	end

	// Mostly short gaps, a few long ones, none while idling is off
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(16, 40);
	endfunction

	// Extremes, small values with many repeats, or any value
	function automatic logic [DW-1:0] rand_value();
		logic [DW-1:0] v;
		int            r;
		r = $urandom_range(0, 99);
		v = $urandom;
		if (r < 3)
			v = MIN_VAL;
		else if (r < 6)
			v = MAX_VAL;
		else if (r < 9)
			v = '0;
		else if (r < 12)
			v = '1;
		else if (r < 45)
			v = DW'($signed($urandom_range(0, 16)) - 8);
		return v;
	endfunction

	// Receiver: random ready with runs, and one long hold-off on request
	initial begin : rx_proc
		int gap;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			if (long_hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat (idle_on ? $urandom_range(1, 12) : 16) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Offer one request beat and hold it until accepted
	task automatic send_item(input mse_pkg::req_t kind, input logic [DW-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		load_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Load n values, then issue the given number of reads
	task automatic run_set(input int n, input int reads);
		for (int i = 0; i < n; i++)
			send_item(mse_pkg::REQ_LOAD, rand_value());
		for (int i = 0; i < reads; i++)
			send_item(mse_pkg::REQ_READ, rand_value());
	endtask

	// Hold the sender until every predicted result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin : main_seq
		int n;
		int reads;
		int k;
		int start;
		sb = new();
		idle_on       = 1'b0;
		long_hold_req = 1'b0;
		sent_count    = 0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		req_type   <= mse_pkg::REQ_LOAD;
		load_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty set read, extremes, repeats, exhaustion, new sets
		send_item(mse_pkg::REQ_READ, '0);
		send_item(mse_pkg::REQ_READ, '1);
		send_item(mse_pkg::REQ_LOAD, MIN_VAL);
		send_item(mse_pkg::REQ_LOAD, MAX_VAL);
		send_item(mse_pkg::REQ_LOAD, '0);
		send_item(mse_pkg::REQ_LOAD, '1);
		send_item(mse_pkg::REQ_LOAD, DW'(1));
		send_item(mse_pkg::REQ_LOAD, DW'(5));
		send_item(mse_pkg::REQ_LOAD, DW'(5));
		send_item(mse_pkg::REQ_LOAD, DW'(-5));
		repeat (9) send_item(mse_pkg::REQ_READ, MAX_VAL);
		send_item(mse_pkg::REQ_LOAD, DW'(7));
		send_item(mse_pkg::REQ_READ, MIN_VAL);
		send_item(mse_pkg::REQ_READ, '0);
		send_item(mse_pkg::REQ_LOAD, DW'(9));
		send_item(mse_pkg::REQ_LOAD, DW'(2));
		send_item(mse_pkg::REQ_READ, '0);
		drain_results();

		// Hold off the receiver so the block fills and stalls its input
		long_hold_req = 1'b1;
		run_set(20, 20);
		drain_results();

		// Fill the store, overflow it, then read the smallest few values
		idle_on = 1'b1;
		run_set(MAX_N + 2, 8);
		drain_results();

		// Random sets, mostly well formed, some noise between them
		start = sent_count;
		while (sent_count - start < RAND_ITEMS) begin
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(41, 160);
			else
				n = $urandom_range(1, 24);
			k = $urandom_range(0, 9);
			if (k < 6)
				reads = n;
			else if (k < 8)
				reads = n + $urandom_range(1, 3);
			else
				reads = $urandom_range(1, n);
			run_set(n, reads);
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4))
					send_item(mse_pkg::req_t'($urandom_range(0, 1)), rand_value());
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end

		// Wind down
		in_valid <= 1'b0;
		drain_results();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
